// File: rtl/core/vpt_pkg.sv
package vpt_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MAX       = 3'd5;

  localparam logic [11:0] RST_VIEWPORT_WIDTH  = 12'd800;
  localparam logic [11:0] RST_VIEWPORT_HEIGHT = 12'd600;

  // The depth multiply splits the scaled z into an unsigned low part of this width
  // and a signed high part.
  localparam int unsigned LO_W = 24;

  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_z;
    logic signed [31:0] inverse_w;
  } out_t;

  // Coordinates that ride along the divider chain.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               w_neg;
  } side_t;

  typedef struct packed {
    logic [11:0]        vp_x;
    logic [11:0]        vp_y;
    logic [11:0]        vp_w;
    logic [11:0]        vp_h;
    logic signed [31:0] d_min;
    logic signed [31:0] d_max;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/vpt_div_cell.sv
module vpt_div_cell #(
  parameter int unsigned NW = 33
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [31:0]           rem_i,
  input  logic [NW-1:0]         nq_i,
  input  logic [31:0]           uw_i,
  input  vpt_pkg::side_t        side_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [31:0]           rem_o,
  output logic [NW-1:0]         nq_o,
  output logic [31:0]           uw_o,
  output vpt_pkg::side_t        side_o
);
  import vpt_pkg::*;

  // One restoring division step: numerator bits leave at the top of nq, quotient bits
  // enter at the bottom.
  logic [32:0]   trial;
  logic          fits;
  logic [31:0]   rem_d;
  logic [NW-1:0] nq_d;
  logic          valid_q;
  logic [31:0]   rem_q;
  logic [NW-1:0] nq_q;
  logic [31:0]   uw_q;
  side_t         side_q;

  always_comb begin
    trial = {rem_i, nq_i[NW-1]};
    fits  = (trial >= {1'b0, uw_i});
    rem_d = fits ? 32'(trial - {1'b0, uw_i}) : trial[31:0];
    nq_d  = {nq_i[NW-2:0], fits};
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      uw_q   <= uw_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign uw_o    = uw_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/vpt_scale.sv
module vpt_scale #(
  parameter int unsigned F   = 16,
  parameter int unsigned NW  = 33,
  parameter int unsigned NXW = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [NW-1:0]         quo_i,
  input  logic [31:0]           rem_i,
  input  logic [31:0]           uw_i,
  input  vpt_pkg::side_t        side_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic signed [NXW-1:0] nx_o,
  output logic signed [NXW-1:0] ny_o,
  output logic signed [NXW-1:0] nz_o,
  output logic signed [31:0]    inv_o
);
  import vpt_pkg::*;

  localparam logic signed [63:0] HALF = 64'sd1 <<< (F - 1);
  localparam logic signed [31:0] ONE  = 32'(64'd1 << F);

  logic [2:0] valid_q;
  logic [2:0] en;

  logic [63:0]        qe;
  logic signed [31:0] inv_d;
  logic signed [31:0] inv1_q, inv2_q, inv3_q;
  logic signed [31:0] x1_q, y1_q, z1_q;
  logic signed [63:0] px_d, py_d, pz_d;
  logic signed [63:0] px_q, py_q, pz_q;
  logic signed [63:0] rx, ry, rz;
  logic signed [NXW-1:0] nx_q, ny_q, nz_q;

  assign en[2]   = ~valid_q[2] | ready_i;
  assign en[1]   = ~valid_q[1] | en[2];
  assign en[0]   = ~valid_q[0] | en[1];
  assign ready_o = en[0];

  // Reciprocal sign and saturation; a zero w gives exactly one.
  always_comb begin
    qe = 64'(quo_i);
    if (uw_i == 32'd0) begin
      inv_d = ONE;
    end else if (!side_i.w_neg) begin
      inv_d = (qe > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : qe[31:0];
    end else begin
      inv_d = (qe > 64'h8000_0000) ? -32'sh8000_0000 : 32'(-qe);
    end
  end

  always_comb begin
    px_d = 64'(x1_q) * 64'(inv1_q);
    py_d = 64'(y1_q) * 64'(inv1_q);
    pz_d = 64'(z1_q) * 64'(inv1_q);
    rx   = (px_q + (px_q[63] ? HALF - 64'sd1 : HALF)) >>> F;
    ry   = (py_q + (py_q[63] ? HALF - 64'sd1 : HALF)) >>> F;
    rz   = (pz_q + (pz_q[63] ? HALF - 64'sd1 : HALF)) >>> F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      inv1_q <= inv_d;
      x1_q   <= side_i.x;
      y1_q   <= side_i.y;
      z1_q   <= side_i.z;
    end
    if (en[1] && valid_q[0]) begin
      inv2_q <= inv1_q;
      px_q   <= px_d;
      py_q   <= py_d;
      pz_q   <= pz_d;
    end
    if (en[2] && valid_q[1]) begin
      inv3_q <= inv2_q;
      nx_q   <= rx[NXW-1:0];
      ny_q   <= ry[NXW-1:0];
      nz_q   <= rz[NXW-1:0];
    end
  end

  assign valid_o = valid_q[2];
  assign nx_o    = nx_q;
  assign ny_o    = ny_q;
  assign nz_o    = nz_q;
  assign inv_o   = inv3_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && uw_i != 32'd0) |-> (rem_i < uw_i))
    else $error("divider remainder not below divisor");
  a_zero_w_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[0] && valid_i && uw_i == 32'd0) |=> (inv1_q == ONE))
    else $error("zero w did not give a reciprocal of one");
  a_pos_w_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en[0] && valid_i && uw_i != 32'd0 && !side_i.w_neg) |=> !inv1_q[31])
    else $error("positive w gave a negative reciprocal");
`endif

endmodule

// File: rtl/core/vpt_map.sv
module vpt_map #(
  parameter int unsigned F   = 16,
  parameter int unsigned NXW = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic signed [NXW-1:0] nx_i,
  input  logic signed [NXW-1:0] ny_i,
  input  logic signed [NXW-1:0] nz_i,
  input  logic signed [31:0]    inv_i,
  input  vpt_pkg::cfg_t         cfg_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output vpt_pkg::out_t         data_o
);
  import vpt_pkg::*;

  localparam int unsigned PW  = NXW + 13;
  localparam int unsigned HW  = NXW - LO_W;
  localparam int unsigned ZLW = 33 + LO_W + 1;
  localparam int unsigned ZHW = 33 + HW;
  localparam int unsigned DW  = 33 + NXW;
  localparam logic signed [DW-1:0] HALF = DW'(1) <<< (F - 1);

  logic [2:0] valid_q;
  logic [2:0] en;

  logic signed [32:0]     dspan;
  logic signed [PW-1:0]   pxw_d, pyh_d, pxw_q, pyh_q;
  logic signed [ZLW-1:0]  zlo_d, zlo_q;
  logic signed [ZHW-1:0]  zhi_d, zhi_q;
  logic signed [31:0]     inv1_q, inv2_q;
  logic signed [PW-1:0]   rx, ry;
  logic [12:0]            ox_sum, oy_sum;
  logic signed [127:0]    ox, oy;
  logic signed [31:0]     sx_d, sy_d, sx2_q, sy2_q;
  logic signed [DW-1:0]   dz_d, dz_q, rz;
  logic signed [31:0]     sz_d;
  out_t                   out_q;

  assign en[2]   = ~valid_q[2] | ready_i;
  assign en[1]   = ~valid_q[1] | en[2];
  assign en[0]   = ~valid_q[0] | en[1];
  assign ready_o = en[0];

  always_comb begin
    dspan = 33'(cfg_i.d_max) - 33'(cfg_i.d_min);
    pxw_d = PW'($signed({1'b0, cfg_i.vp_w})) * PW'(nx_i);
    pyh_d = PW'(-$signed({1'b0, cfg_i.vp_h})) * PW'(ny_i);
    zlo_d = ZLW'(dspan) * ZLW'($signed({1'b0, nz_i[LO_W-1:0]}));
    zhi_d = ZHW'(dspan) * ZHW'($signed(nz_i[NXW-1:LO_W]));
  end

  // Halve the x and y products with ties away from zero, then add the origins.
  always_comb begin
    rx     = (pxw_q + (pxw_q[PW-1] ? PW'(0) : PW'(1))) >>> 1;
    ry     = (pyh_q + (pyh_q[PW-1] ? PW'(0) : PW'(1))) >>> 1;
    ox_sum = 13'(cfg_i.vp_x) + 13'(cfg_i.vp_w);
    oy_sum = 13'(cfg_i.vp_y) + 13'(cfg_i.vp_h);
    ox     = $signed(128'(ox_sum) << (F - 1));
    oy     = $signed(128'(oy_sum) << (F - 1));
    sx_d   = sat32(128'(rx) + ox);
    sy_d   = sat32(128'(ry) + oy);
    dz_d   = (DW'(zhi_q) <<< LO_W) + DW'(zlo_q);
  end

  always_comb begin
    rz   = (dz_q + (dz_q[DW-1] ? HALF - DW'(1) : HALF)) >>> F;
    sz_d = sat32(128'(rz) + 128'(cfg_i.d_min));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      pxw_q  <= pxw_d;
      pyh_q  <= pyh_d;
      zlo_q  <= zlo_d;
      zhi_q  <= zhi_d;
      inv1_q <= inv_i;
    end
    if (en[1] && valid_q[0]) begin
      sx2_q  <= sx_d;
      sy2_q  <= sy_d;
      dz_q   <= dz_d;
      inv2_q <= inv1_q;
    end
    if (en[2] && valid_q[1]) begin
      out_q.screen_x  <= sx2_q;
      out_q.screen_y  <= sy2_q;
      out_q.screen_z  <= sz_d;
      out_q.inverse_w <= inv2_q;
    end
  end

  assign valid_o = valid_q[2];
  assign data_o  = out_q;

endmodule

// File: rtl/core/viewport_transform.sv
// Stages: a divider chain of one cell per reciprocal bit, then six arithmetic stages.
// Throughput: one vertex per cycle while out_ready_i is high; a full stage keeps its
// item while the stage ahead of it cannot take it, and empty slots still fill.
// Reset: rst_ni clears all valid flags and loads the register defaults
// (viewport 800 by 600 at the origin, depth range 0 to 1.0).
module viewport_transform #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vpt_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vpt_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [vpt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vpt_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import vpt_pkg::*;

  localparam int unsigned F   = FRACTION_BITS;
  // The rounded numerator 2^(2F) + |w|/2 needs this many bits, and so does the quotient.
  localparam int unsigned NW  = (2 * F >= 31) ? 2 * F + 1 : 31;
  localparam int unsigned NXW = 64 - F;

  // Configuration registers. The user must write them only while the pipeline is empty,
  // as the block does not enforce it and the later stages read them directly.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vp_x  <= '0;
      cfg_q.vp_y  <= '0;
      cfg_q.vp_w  <= RST_VIEWPORT_WIDTH;
      cfg_q.vp_h  <= RST_VIEWPORT_HEIGHT;
      cfg_q.d_min <= '0;
      cfg_q.d_max <= 32'(64'd1 << F);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_VIEWPORT_X:      cfg_q.vp_x  <= cfg_data_i[11:0];
        REG_VIEWPORT_Y:      cfg_q.vp_y  <= cfg_data_i[11:0];
        REG_VIEWPORT_WIDTH:  cfg_q.vp_w  <= cfg_data_i[11:0];
        REG_VIEWPORT_HEIGHT: cfg_q.vp_h  <= cfg_data_i[11:0];
        REG_DEPTH_MIN:       cfg_q.d_min <= cfg_data_i;
        REG_DEPTH_MAX:       cfg_q.d_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The divider works on the magnitude of w. The most negative w has a magnitude
  // of 2^31, which still fits the unsigned 32-bit divisor.
  logic [31:0] uw_in;
  always_comb begin
    uw_in = in_data_i.clip_w[31] ? 32'(-in_data_i.clip_w) : 32'(in_data_i.clip_w);
  end

  // Chain of division cells. Each cell produces one quotient bit and hands the
  // partial remainder to its neighbor together with the vertex coordinates.
  // Every cell has its own skid-free register slot, so the chain keeps moving
  // while slots ahead of a stalled result are empty.
  logic          cv   [0:NW];
  logic          crdy [0:NW];
  logic [31:0]   crem [0:NW];
  logic [NW-1:0] cnq  [0:NW];
  logic [31:0]   cuw  [0:NW];
  side_t         cside[0:NW];

  assign cv[0]            = in_valid_i;
  assign in_ready_o       = crdy[0];
  assign crem[0]          = '0;
  assign cnq[0]           = NW'(64'd1 << (2 * F)) + NW'(uw_in >> 1);
  assign cuw[0]           = uw_in;
  assign cside[0].x       = in_data_i.clip_x;
  assign cside[0].y       = in_data_i.clip_y;
  assign cside[0].z       = in_data_i.clip_z;
  assign cside[0].w_neg   = in_data_i.clip_w[31];

  for (genvar i = 0; i < NW; i++) begin : g_div
    vpt_div_cell #(
      .NW(NW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .ready_o (crdy[i]),
      .rem_i   (crem[i]),
      .nq_i    (cnq[i]),
      .uw_i    (cuw[i]),
      .side_i  (cside[i]),
      .valid_o (cv[i+1]),
      .ready_i (crdy[i+1]),
      .rem_o   (crem[i+1]),
      .nq_o    (cnq[i+1]),
      .uw_o    (cuw[i+1]),
      .side_o  (cside[i+1])
    );
  end

  // Reciprocal saturation and the perspective scaling of x, y and z.
  logic                  s_valid;
  logic                  s_ready;
  logic signed [NXW-1:0] s_nx, s_ny, s_nz;
  logic signed [31:0]    s_inv;

  vpt_scale #(
    .F   (F),
    .NW  (NW),
    .NXW (NXW)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[NW]),
    .ready_o (crdy[NW]),
    .quo_i   (cnq[NW]),
    .rem_i   (crem[NW]),
    .uw_i    (cuw[NW]),
    .side_i  (cside[NW]),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .nx_o    (s_nx),
    .ny_o    (s_ny),
    .nz_o    (s_nz),
    .inv_o   (s_inv)
  );

  // Viewport and depth mapping. Its last stage is the output register, so a
  // result waiting for transfer does not stop the stages behind it from filling.
  vpt_map #(
    .F   (F),
    .NXW (NXW)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .nx_i    (s_nx),
    .ny_i    (s_ny),
    .nz_i    (s_nz),
    .inv_i   (s_inv),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");
`endif

endmodule
